### hdl/nta_pkg.sv
// Shared item types, controller/datapath links and text helpers for the name table.
`timescale 1ns / 1ps
`default_nettype none

package nta_pkg;

  localparam int TEXT_CHARS = 10;
  localparam int TEXT_W     = TEXT_CHARS * 8;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [6:0]  slot;
    logic [6:0]  live_entries;
    logic [63:0] text_head;
    logic [15:0] text_tail;
  } in_item_t;

  typedef struct packed {
    logic [6:0] match_index;
    logic       ambiguous;
    logic       bad_count;
  } out_item_t;

  typedef struct packed {
    logic take;    // request item accepted this cycle
    logic step;    // read the next table entry
    logic finish;  // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic skip;    // empty word or zero count: nothing to scan
    logic last;    // the read being issued is the final one
  } dp_stat_t;

  // Ends the text at its first zero character and at the configured name length.
  function automatic logic [TEXT_W-1:0] norm_text(input logic [63:0] head,
                                                  input logic [15:0] tail,
                                                  input int nchars);
    logic [TEXT_W-1:0] raw;
    logic [TEXT_W-1:0] res;
    logic              ended;
    logic [7:0]        c;
    raw   = {tail, head};
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      c = raw[i*8 +: 8];
      if (i >= nchars || c == 8'd0) begin
        ended = 1'b1;
      end
      res[i*8 +: 8] = ended ? 8'd0 : c;
    end
    return res;
  endfunction

  // Both texts are normalized, so every nonzero word character must agree.
  function automatic logic is_prefix(input logic [TEXT_W-1:0] word,
                                     input logic [TEXT_W-1:0] name);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if (word[i*8 +: 8] != 8'd0 && word[i*8 +: 8] != name[i*8 +: 8]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

### hdl/name_table_abbreviation_match.sv
// Top level of the name table with unique-prefix abbreviation lookup.
//
// Request channel (req_valid/req_ready/req): a write item (kind 0) stores a
// zero-padded name at entry slot and completes in the cycle it is accepted;
// it produces no result. A query item (kind 1) searches the first
// live_entries entries for the word and produces one result item on the
// response channel (rsp_valid/rsp_ready/rsp).
// A query reads one table entry per cycle from the single-port name memory,
// so it steps through the prepare, scan (clamped count), drain and finish
// states before its result is registered; an empty word or zero count
// skips scan and drain. req_ready is low while a query is in progress.
// The result register frees the search side: the block takes the next item
// while a result still waits, and only stalls at the end of the next query
// if the receiver has not taken the earlier result by then.
// Reset clears the controller and the response valid; table contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module name_table_abbreviation_match #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_CHARS  = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire nta_pkg::in_item_t  req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output nta_pkg::out_item_t      rsp
);
  import nta_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  nta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  nta_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_CHARS  (NAME_CHARS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (dp_cmd),
    .stat (dp_stat),
    .rsp  (rsp)
  );

  // A new result must never overwrite one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.finish |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while pending");

  // No request item is taken while the table is being scanned.
  a_busy_scan: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.step |-> !req_ready)
    else $error("request ready during scan");

  // An ambiguous result never carries an entry index.
  a_ambig_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.ambiguous) |-> (rsp.match_index == '0))
    else $error("ambiguous result with nonzero index");

  // A scan read is always followed by its evaluation before the result loads.
  a_finish_after_read: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.step |=> !dp_cmd.finish)
    else $error("result loaded before last entry was evaluated");

endmodule

`default_nettype wire

### hdl/nta_datapath.sv
// Datapath: name memory, query registers, scan evaluation and result register.
`timescale 1ns / 1ps
`default_nettype none

module nta_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int NAME_CHARS  = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nta_pkg::in_item_t req,
  input  wire nta_pkg::dp_cmd_t  cmd,
  output nta_pkg::dp_stat_t      stat,
  output nta_pkg::out_item_t     rsp
);
  import nta_pkg::*;

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int CW0 = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = (CW0 > 7) ? CW0 : 7;
  localparam int NW  = NAME_CHARS * 8;

  logic [NW-1:0]     mem [MAX_ENTRIES];
  logic [NW-1:0]     rdata;

  logic [TEXT_W-1:0] req_text;
  logic [CW-1:0]     slot_ext;
  logic [CW-1:0]     cnt_ext;
  logic              slot_ok;
  logic              cnt_over;

  logic [TEXT_W-1:0] word_q;
  logic [CW-1:0]     count_q;
  logic              bad_q;
  logic [CW-1:0]     addr;
  logic              rd_pending;
  logic [CW-1:0]     rd_idx;

  logic              exact_found;
  logic [CW-1:0]     exact_idx;
  logic              pre_found;
  logic [CW-1:0]     pre_idx;
  logic [TEXT_W-1:0] first_q;
  logic              ambig_q;

  logic [TEXT_W-1:0] name_cur;
  logic              hit_exact;
  logic              hit_prefix;

  always_comb begin
    req_text   = norm_text(req.text_head, req.text_tail, NAME_CHARS);
    slot_ext   = CW'(req.slot);
    cnt_ext    = CW'(req.live_entries);
    slot_ok    = (slot_ext != '0) && (slot_ext <= CW'(MAX_ENTRIES));
    cnt_over   = cnt_ext > CW'(MAX_ENTRIES);
    name_cur   = TEXT_W'(rdata);
    hit_exact  = (name_cur == word_q);
    hit_prefix = is_prefix(word_q, name_cur);
    stat.skip  = (count_q == '0) || (word_q[7:0] == 8'd0);
    stat.last  = (CW'(addr + 1'b1) == count_q);
  end

  // Table entries are written on accept and read one per cycle during a scan.
  always_ff @(posedge clk) begin
    if (cmd.take && req.kind == KIND_WRITE && slot_ok) begin
      mem[IW'(slot_ext - 1'b1)] <= req_text[NW-1:0];
    end
    if (cmd.step) begin
      rdata <= mem[addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= CW'(addr + 1'b1);
    if (cmd.take && req.kind == KIND_QUERY) begin
      word_q      <= req_text;
      count_q     <= cnt_over ? CW'(MAX_ENTRIES) : cnt_ext;
      bad_q       <= cnt_over;
      addr        <= '0;
      exact_found <= 1'b0;
      pre_found   <= 1'b0;
      ambig_q     <= 1'b0;
    end else begin
      if (cmd.step) begin
        addr <= CW'(addr + 1'b1);
      end
      if (rd_pending) begin
        if (hit_exact && !exact_found) begin
          exact_found <= 1'b1;
          exact_idx   <= rd_idx;
        end
        if (hit_prefix) begin
          if (!pre_found) begin
            pre_found <= 1'b1;
            pre_idx   <= rd_idx;
            first_q   <= name_cur;
          end else if (name_cur != first_q) begin
            ambig_q <= 1'b1;
          end
        end
      end
    end
  end

  // An exact hit wins over any prefix result; ambiguity only counts without one.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.bad_count <= bad_q;
      priority if (exact_found) begin
        rsp.match_index <= exact_idx[6:0];
        rsp.ambiguous   <= 1'b0;
      end else if (pre_found && !ambig_q) begin
        rsp.match_index <= pre_idx[6:0];
        rsp.ambiguous   <= 1'b0;
      end else begin
        rsp.match_index <= '0;
        rsp.ambiguous   <= pre_found && ambig_q;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/nta_ctrl.sv
// Controller: sequences write, scan and result delivery, and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module nta_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_kind,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  input  wire nta_pkg::dp_stat_t stat,
  output nta_pkg::dp_cmd_t      cmd
);
  import nta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  always_comb begin
    req_ready  = (state == S_IDLE);
    cmd.take   = req_valid && (state == S_IDLE);
    cmd.step   = (state == S_SCAN);
    cmd.finish = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.take && req_kind == KIND_QUERY) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= stat.skip ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          if (stat.last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/name_table_abbreviation_match_tb.sv
// Self-checking testbench for the name table with unique-prefix abbreviation lookup.
`timescale 1ns / 1ps

module name_table_abbreviation_match_tb;
  import nta_pkg::*;

  localparam int MAX_ENTRIES    = 64;
  localparam int RANDOM_ITEMS   = 640;
  localparam int MAX_IDLE       = 17;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int POOL_SIZE      = 16;

  typedef struct {
    in_item_t  item;
    bit        has_answer;
    out_item_t answer;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  in_item_t  req;
  logic      rsp_valid;
  logic      rsp_ready;
  out_item_t rsp;

  logic [79:0] stored_names [1:MAX_ENTRIES];
  out_item_t   expected_results [$];
  logic [79:0] name_pool [POOL_SIZE];
  int          pool_len [POOL_SIZE];

  int  mismatches;
  int  queries_sent;
  int  writes_sent;
  int  results_checked;
  int  ambiguous_seen;
  int  clamped_seen;
  int  quiet_cycles;
  bit  send_idle;
  bit  recv_idle;

  name_table_abbreviation_match i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A text stops at its first zero character; everything after it reads as zero.
  function automatic logic [79:0] clean_text(input logic [63:0] head, input logic [15:0] tail);
    logic [79:0] raw;
    logic [79:0] res;
    bit          ended;
    raw   = {tail, head};
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (raw[i*8 +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[i*8 +: 8] = raw[i*8 +: 8];
      end
    end
    return res;
  endfunction

  function automatic bit word_prefixes(input logic [79:0] word, input logic [79:0] name);
    bit done;
    done = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (!done) begin
        if (word[i*8 +: 8] == 8'd0) begin
          done = 1'b1;
        end else if (word[i*8 +: 8] != name[i*8 +: 8]) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic out_item_t predict_lookup(input logic [79:0] word, input logic [6:0] count_in);
    out_item_t   res;
    int          cnt;
    int          hit;
    logic [79:0] first_name;
    res = '0;
    cnt = count_in;
    if (cnt > MAX_ENTRIES) begin
      cnt           = MAX_ENTRIES;
      res.bad_count = 1'b1;
    end
    if (cnt == 0 || word[7:0] == 8'd0) begin
      return res;
    end
    hit = 0;
    for (int i = 1; i <= cnt && hit == 0; i++) begin
      if (stored_names[i] == word) begin
        hit = i;
      end
    end
    if (hit == 0) begin
      for (int i = 1; i <= cnt && hit == 0; i++) begin
        if (word_prefixes(word, stored_names[i])) begin
          hit = i;
        end
      end
      if (hit != 0) begin
        first_name = stored_names[hit];
        for (int j = hit + 1; j <= cnt; j++) begin
          if (word_prefixes(word, stored_names[j]) && stored_names[j] != first_name) begin
            res.ambiguous = 1'b1;
            hit           = 0;
            break;
          end
        end
      end
    end
    res.match_index = 7'(hit);
    return res;
  endfunction

  function automatic dir_row_t row(input logic kind, input int slot, input int live,
                                   input logic [63:0] head, input logic [15:0] tail,
                                   input bit has_answer, input int idx, input bit amb,
                                   input bit bad);
    dir_row_t r;
    r.item.kind          = kind;
    r.item.slot          = 7'(slot);
    r.item.live_entries  = 7'(live);
    r.item.text_head     = head;
    r.item.text_tail     = tail;
    r.has_answer         = has_answer;
    r.answer.match_index = 7'(idx);
    r.answer.ambiguous   = amb;
    r.answer.bad_count   = bad;
    return r;
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  // Keeps the first keep characters of a name, then ends it, sometimes with junk after the zero.
  function automatic logic [79:0] make_text(input logic [79:0] name, input int keep);
    logic [79:0] res;
    bit          junk;
    res  = '0;
    junk = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 10; i++) begin
      if (i < keep) begin
        res[i*8 +: 8] = name[i*8 +: 8];
      end else if (i > keep && junk) begin
        res[i*8 +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return res;
  endfunction

  // Presents one item, waits for it to be taken, and updates the expected table.
  task automatic send_item(input in_item_t item, input bit has_answer, input out_item_t answer);
    int          gap;
    logic [79:0] text;
    out_item_t   predicted;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    text = clean_text(item.text_head, item.text_tail);
    if (item.kind == KIND_WRITE) begin
      writes_sent++;
      if (item.slot >= 1 && item.slot <= MAX_ENTRIES) begin
        stored_names[item.slot] = text;
      end
    end else begin
      queries_sent++;
      predicted = predict_lookup(text, item.live_entries);
      expected_results.push_back(has_answer ? answer : predicted);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stalls, each result checked against the oldest expectation.
  initial begin
    int        stall;
    out_item_t want;
    rsp_ready <= 1'b0;
    recv_idle = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      results_checked++;
      if (rsp.ambiguous === 1'b1) begin
        ambiguous_seen++;
      end
      if (rsp.bad_count === 1'b1) begin
        clamped_seen++;
      end
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: index %0d ambiguous %0b bad_count %0b",
                 $time, rsp.match_index, rsp.ambiguous, rsp.bad_count);
      end else begin
        want = expected_results.pop_front();
        if (rsp.match_index !== want.match_index) begin
          mismatches++;
          $display("%0t: match_index expected %0d got %0d", $time, want.match_index,
                   rsp.match_index);
        end
        if (rsp.ambiguous !== want.ambiguous) begin
          mismatches++;
          $display("%0t: ambiguous expected %0b got %0b", $time, want.ambiguous, rsp.ambiguous);
        end
        if (rsp.bad_count !== want.bad_count) begin
          mismatches++;
          $display("%0t: bad_count expected %0b got %0b", $time, want.bad_count, rsp.bad_count);
        end
      end
      if (results_checked % 25 == 0) begin
        recv_idle = ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    dir_row_t    dir_rows [$];
    in_item_t    item;
    out_item_t   none;
    logic [79:0] text;
    int          n;
    int          r;
    int          c;
    int          p;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    none      = '0;
    send_idle = 1'b1;
    mismatches      = 0;
    queries_sent    = 0;
    writes_sent     = 0;
    results_checked = 0;
    ambiguous_seen  = 0;
    clamped_seen    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Every entry gets a distinct name first, so no query ever reads an unwritten entry.
    for (int i = 1; i <= MAX_ENTRIES; i++) begin
      item           = '0;
      item.kind      = KIND_WRITE;
      item.slot      = 7'(i);
      item.text_head = {48'h0, 8'(8'h40 + i), 8'h46};
      send_item(item, 1'b0, none);
    end

    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h8046, 16'h0, 1, 64, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 100, 64'h8046, 16'h0, 1, 64, 0, 1));
    dir_rows.push_back(row(KIND_QUERY, 0, 127, 64'h8046, 16'h0, 1, 64, 0, 1));
    dir_rows.push_back(row(KIND_QUERY, 0, 0, 64'h8046, 16'h0, 1, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h0, 16'h0, 1, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 1, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h46, 16'h0, 1, 0, 1, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 1, 64'h46, 16'h0, 1, 1, 0, 0));
    // Writes to slot 0 and past the table are dropped.
    dir_rows.push_back(row(KIND_WRITE, 0, 0, 64'h7A7A, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 65, 0, 64'h7A7A, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 127, 127, 64'h7A7A, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 1, 0, 64'h6261, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 2, 0, 64'h63_6261, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 3, 0, 64'h6261, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 3, 64'h6261, 16'h0, 1, 1, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 3, 64'h61, 16'h0, 1, 0, 1, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 3, 64'h63_6261, 16'h0, 1, 2, 0, 0));
    // Junk after the terminator must not make entry 2 differ from the other "ab" entries.
    dir_rows.push_back(row(KIND_WRITE, 2, 0, 64'hFF00_6261, 16'hFFFF, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 3, 64'h61, 16'h0, 1, 1, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 5, 64'h61, 16'h0, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 64, 0, 64'h7A7A_7A7A_7A7A_7A7A, 16'h7A7A, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h7A7A_7A7A_7A7A_7A7A, 16'h7A7A, 1, 64, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h7A7A_7A7A_7A7A_7A7A, 16'h007A, 1, 64, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 63, 64'h7A7A_7A7A_7A7A_7A7A, 16'h007A, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_WRITE, 63, 0, 64'h80FF_80FF_80FF_80FF, 16'hFF80, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 63, 64'h80FF_80FF_80FF_80FF, 16'hFF80, 0, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 64, 64'h78_6261, 16'h0, 1, 0, 0, 0));
    dir_rows.push_back(row(KIND_QUERY, 0, 65, 64'h7A7A, 16'h0, 1, 64, 0, 1));
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].item, dir_rows[k].has_answer, dir_rows[k].answer);
    end

    // A small alphabet makes shared prefixes, duplicates and ambiguity common.
    for (int i = 0; i < POOL_SIZE; i++) begin
      name_pool[i] = '0;
      pool_len[i]  = (i < 2) ? 10 : $urandom_range(1, 6);
      for (int j = 0; j < pool_len[i]; j++) begin
        name_pool[i][j*8 +: 8] = rand_char();
      end
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 64 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
      end
      r    = $urandom_range(0, 99);
      item = '0;
      p    = $urandom_range(0, POOL_SIZE - 1);
      if (r < 5) begin
        item.kind         = 1'($urandom_range(0, 1));
        item.slot         = 7'($urandom_range(0, 127));
        item.live_entries = 7'($urandom_range(0, 127));
        item.text_head    = {$urandom, $urandom};
        item.text_tail    = 16'($urandom_range(0, 65535));
        if (item.kind == KIND_QUERY || (item.slot >= 1 && item.slot <= MAX_ENTRIES)) begin
          n++;
        end
      end else if (r < 8) begin
        item.kind      = KIND_WRITE;
        item.slot      = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
        text           = make_text(name_pool[p], pool_len[p]);
        item.text_head = text[63:0];
        item.text_tail = text[79:64];
      end else if (r < 40) begin
        item.kind      = KIND_WRITE;
        item.slot      = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(1, 12))
                                                     : 7'($urandom_range(1, MAX_ENTRIES));
        text           = make_text(name_pool[p], pool_len[p]);
        item.text_head = text[63:0];
        item.text_tail = text[79:64];
        n++;
      end else begin
        item.kind = KIND_QUERY;
        c         = $urandom_range(0, 99);
        if (c < 5) begin
          item.live_entries = 7'd0;
        end else if (c < 12) begin
          item.live_entries = 7'($urandom_range(65, 127));
        end else if (c < 50) begin
          item.live_entries = 7'($urandom_range(1, 16));
        end else begin
          item.live_entries = 7'($urandom_range(1, MAX_ENTRIES));
        end
        text           = make_text(name_pool[p], $urandom_range(0, pool_len[p]));
        item.text_head = text[63:0];
        item.text_tail = text[79:64];
        n++;
      end
      send_item(item, 1'b0, none);
    end
    req_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d queries and %0d table writes; %0d results were checked.",
             queries_sent, writes_sent, results_checked);
    $display("Results flagged ambiguous: %0d, with clamped count: %0d; %0d field errors.",
             ambiguous_seen, clamped_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/nta_pkg.sv
hdl/nta_datapath.sv
hdl/nta_ctrl.sv
hdl/name_table_abbreviation_match.sv
tb/sv/name_table_abbreviation_match_tb.sv
